/* sv/plwp_pkg.sv */
// ----------------------------------------------------------------------------
// plwp_pkg
// Shared types and constants for the polyline-within-polygon test core.
// ----------------------------------------------------------------------------
package plwp_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF   = 32;

  localparam int unsigned STEP_W      = 5;
  localparam int unsigned NPAIR       = 7;
  localparam int unsigned PAIR_W      = 3;
  localparam int unsigned STEPS_POINT = 4;   // on-edge and ray pairs
  localparam int unsigned STEPS_ALL   = 14;  // plus segment crossing pairs

  // compare pairs
  localparam int unsigned PR_ONEDGE = 0;
  localparam int unsigned PR_RAY    = 1;
  localparam int unsigned PR_PARAL  = 2;
  localparam int unsigned PR_TS1A   = 3;
  localparam int unsigned PR_TS1B   = 4;
  localparam int unsigned PR_TS2A   = 5;
  localparam int unsigned PR_TS2B   = 6;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_POINT  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_CALC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              issue;
    logic [STEP_W-1:0] step;
  } edge_ctrl_t;

  typedef struct packed {
    logic [NPAIR-1:0] gt;
    logic [NPAIR-1:0] eq;
  } edge_flags_t;

endpackage

/* sv/plwp_vtx_ram.sv */
// ----------------------------------------------------------------------------
// plwp_vtx_ram
// Vertex table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module plwp_vtx_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/plwp_edge_unit.sv */
// ----------------------------------------------------------------------------
// plwp_edge_unit
// Shared multiply/compare unit: operand select, one signed multiplier,
// and a product compare that records the sign of each product pair.
// ----------------------------------------------------------------------------
module plwp_edge_unit #(
  parameter int unsigned CW = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  plwp_pkg::edge_ctrl_t  ctrl_i,
  input  logic signed [CW-1:0]  ax_i,
  input  logic signed [CW-1:0]  ay_i,
  input  logic signed [CW-1:0]  bx_i,
  input  logic signed [CW-1:0]  by_i,
  input  logic signed [CW-1:0]  px_i,
  input  logic signed [CW-1:0]  py_i,
  input  logic signed [CW-1:0]  qx_i,
  input  logic signed [CW-1:0]  qy_i,
  output plwp_pkg::edge_flags_t flags_o
);
  import plwp_pkg::*;

  localparam int unsigned DW = CW + 1;
  localparam int unsigned OW = CW + 2;
  localparam int unsigned PW = 2 * OW;

  logic signed [DW-1:0] u0, v0, u1, v1, d0, d1;
  logic signed [OW-1:0] opa_d, opb_d, opa_q, opb_q;
  logic signed [PW-1:0] prod_q, first_q;
  logic                 v1_q, v2_q;
  logic [STEP_W-1:0]    s1_q, s2_q;
  logic                 ray_neg;
  logic signed [DW-1:0] dxr;
  logic [PAIR_W-1:0]    pair;
  edge_flags_t          flags_q;

  assign ray_neg = (bx_i != ax_i) && (py_i != ay_i) && (by_i != ay_i) &&
                   ((bx_i < ax_i) ^ (py_i < ay_i) ^ (by_i < ay_i));
  assign dxr = DW'(px_i) - DW'(ax_i);

  function automatic logic signed [OW-1:0] absx(input logic signed [DW-1:0] v);
    logic signed [OW-1:0] e;
    e = OW'(v);
    return (v < 0) ? -e : e;
  endfunction

  always_comb begin
    u0 = '0; v0 = '0; u1 = '0; v1 = '0;
    case (ctrl_i.step)
      5'd0:  begin u0 = DW'(px_i); v0 = DW'(ax_i); u1 = DW'(py_i); v1 = DW'(by_i); end
      5'd1:  begin u0 = DW'(px_i); v0 = DW'(bx_i); u1 = DW'(py_i); v1 = DW'(ay_i); end
      5'd2:  begin u0 = DW'(bx_i); v0 = DW'(ax_i); u1 = DW'(py_i); v1 = DW'(ay_i); end
      5'd3:  begin u0 = DW'(px_i); v0 = DW'(ax_i); u1 = DW'(by_i); v1 = DW'(ay_i); end
      5'd4:  begin u0 = DW'(bx_i); v0 = DW'(ax_i); u1 = DW'(py_i); v1 = DW'(qy_i); end
      5'd5:  begin u0 = DW'(by_i); v0 = DW'(ay_i); u1 = DW'(px_i); v1 = DW'(qx_i); end
      5'd6:  begin u0 = DW'(qx_i); v0 = DW'(ax_i); u1 = DW'(by_i); v1 = DW'(ay_i); end
      5'd7:  begin u0 = DW'(bx_i); v0 = DW'(ax_i); u1 = DW'(qy_i); v1 = DW'(ay_i); end
      5'd8:  begin u0 = DW'(px_i); v0 = DW'(ax_i); u1 = DW'(by_i); v1 = DW'(ay_i); end
      5'd9:  begin u0 = DW'(bx_i); v0 = DW'(ax_i); u1 = DW'(py_i); v1 = DW'(ay_i); end
      5'd10: begin u0 = DW'(ax_i); v0 = DW'(qx_i); u1 = DW'(py_i); v1 = DW'(qy_i); end
      5'd11: begin u0 = DW'(px_i); v0 = DW'(qx_i); u1 = DW'(ay_i); v1 = DW'(qy_i); end
      5'd12: begin u0 = DW'(bx_i); v0 = DW'(qx_i); u1 = DW'(py_i); v1 = DW'(qy_i); end
      5'd13: begin u0 = DW'(px_i); v0 = DW'(qx_i); u1 = DW'(by_i); v1 = DW'(qy_i); end
      default: begin u0 = '0; v0 = '0; u1 = '0; v1 = '0; end
    endcase
    d0 = u0 - v0;
    d1 = u1 - v1;
    opa_d = OW'(d0);
    opb_d = OW'(d1);
    if (ctrl_i.step == STEP_W'(2)) begin
      opa_d = absx(d0);
      opb_d = absx(d1);
    end else if (ctrl_i.step == STEP_W'(3)) begin
      // T = |dx| on the negative branch, dx + 1 otherwise; D = |den|
      opa_d = ray_neg ? absx(dxr) : (OW'(dxr) + OW'(1));
      opb_d = absx(d1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
    end
  end

  assign pair = s2_q[PAIR_W:1];

  always_ff @(posedge clk_i) begin
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    s1_q   <= ctrl_i.step;
    prod_q <= opa_q * opb_q;
    s2_q   <= s1_q;
    if (v2_q) begin
      if (!s2_q[0]) begin
        first_q <= prod_q;
      end else begin
        flags_q.gt[pair] <= first_q > prod_q;
        flags_q.eq[pair] <= first_q == prod_q;
      end
    end
  end

  assign flags_o = flags_q;

endmodule

/* sv/polyline_within_polygon_test_core.sv */
// ----------------------------------------------------------------------------
// polyline_within_polygon_test_core
// Polygon vertex table with even-odd point test and segment crossing check.
// ----------------------------------------------------------------------------
// Clear and append items finish without raising busy. A point item walks the
// vertex table one vertex at a time through a single registered read port and
// runs each edge through one shared multiplier: the on-edge and ray products
// for the first point of a polyline, and the segment crossing products as well
// for every later point. busy is high meanwhile. The result strobe lasts one
// cycle and cannot be held off by the receiver.
module polyline_within_polygon_test_core #(
  parameter int unsigned MAX_VERTICES = plwp_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = plwp_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  input  logic        ring_start_i,
  input  logic        last_i,
  output logic        result_valid_o,
  output logic        within_res_o,
  output logic        vertices_dropped_o
);
  import plwp_pkg::*;

  localparam int unsigned CW   = COORD_BITS;
  localparam int unsigned IW   = $clog2(MAX_VERTICES);
  localparam int unsigned CNTW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned VW   = 2 * CW + 1;

  state_e               state_q, state_d;
  logic [IW-1:0]        idx_q;
  logic [STEP_W-1:0]    k_q, k_last;
  logic [CNTW-1:0]      cnt_q;
  logic                 ovf_q, have_prev_q, inside_q, last_q;
  logic                 parity_q, onedge_q, cross_q;
  logic signed [CW-1:0] px_q, py_q, qx_q, qy_q, ax_q, ay_q, bx_q, by_q;
  logic                 rv_q, within_q, dropped_q;
  logic                 accept, we, final_v;
  logic [VW-1:0]        rdata, wdata;
  logic                 rd_mark;
  logic signed [CW-1:0] rd_x, rd_y;
  edge_ctrl_t           ctrl;
  edge_flags_t          flags;
  logic                 onedge, hit, seg_cross, straddle, dxneg, rneg, ts1, ts2;
  logic                 lt3, lt4, lt5, lt6, line_ok;

  assign accept  = start && !busy;
  assign busy    = state_q != ST_IDLE;
  assign we      = accept && (op_e'(op_i) == OP_APPEND) && (cnt_q < CNTW'(MAX_VERTICES));
  assign wdata   = {ring_start_i || (cnt_q == '0), x_i[CW-1:0], y_i[CW-1:0]};
  assign rd_mark = rdata[VW-1];
  assign rd_x    = rdata[2*CW-1:CW];
  assign rd_y    = rdata[CW-1:0];
  assign final_v = (CNTW'(idx_q) + CNTW'(1)) == cnt_q;
  assign k_last  = have_prev_q ? STEP_W'(STEPS_ALL + 2) : STEP_W'(STEPS_POINT + 2);

  plwp_vtx_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[IW-1:0]),
    .wdata_i (wdata),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  plwp_edge_unit #(.CW(CW)) u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .ax_i    (ax_q),
    .ay_i    (ay_q),
    .bx_i    (bx_q),
    .by_i    (by_q),
    .px_i    (px_q),
    .py_i    (py_q),
    .qx_i    (qx_q),
    .qy_i    (qy_q),
    .flags_o (flags)
  );

  // edge decisions from the recorded product signs
  always_comb begin
    onedge = flags.eq[PR_ONEDGE] &&
             !((px_q > ax_q && px_q > bx_q) || (px_q < ax_q && px_q < bx_q)) &&
             !((py_q > ay_q && py_q > by_q) || (py_q < ay_q && py_q < by_q));
    straddle = (ay_q > py_q) != (by_q > py_q);
    dxneg    = px_q < ax_q;
    rneg     = (bx_q != ax_q) && (py_q != ay_q) && (by_q != ay_q) &&
               ((bx_q < ax_q) ^ (py_q < ay_q) ^ (by_q < ay_q));
    if (rneg) begin
      hit = dxneg && !flags.gt[PR_RAY] && !flags.eq[PR_RAY];
    end else begin
      hit = dxneg || flags.gt[PR_RAY] || flags.eq[PR_RAY];
    end
    hit = hit && straddle;
    lt3 = !flags.gt[PR_TS1A] && !flags.eq[PR_TS1A];
    lt4 = !flags.gt[PR_TS1B] && !flags.eq[PR_TS1B];
    lt5 = !flags.gt[PR_TS2A] && !flags.eq[PR_TS2A];
    lt6 = !flags.gt[PR_TS2B] && !flags.eq[PR_TS2B];
    ts1 = (flags.gt[PR_TS1A] && lt4) || (lt3 && flags.gt[PR_TS1B]);
    ts2 = (flags.gt[PR_TS2A] && lt6) || (lt5 && flags.gt[PR_TS2B]);
    seg_cross = have_prev_q && !flags.eq[PR_PARAL] && ts1 && ts2;
    line_ok = inside_q && parity_q && !onedge_q && !cross_q;
  end

  always_comb begin
    state_d    = state_q;
    ctrl.issue = 1'b0;
    ctrl.step  = k_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && op_e'(op_i) == OP_POINT) begin
          state_d = (cnt_q >= CNTW'(2)) ? ST_FETCH : ST_DONE;
        end
      end
      ST_FETCH: state_d = ST_LOAD;
      ST_LOAD: begin
        if (idx_q == '0) begin
          state_d = ST_FETCH;
        end else if (rd_mark) begin
          state_d = final_v ? ST_DONE : ST_FETCH;
        end else begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        ctrl.issue = k_q < (k_last - STEP_W'(2));
        if (k_q == k_last) begin
          state_d = final_v ? ST_DONE : ST_FETCH;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      have_prev_q <= 1'b0;
      inside_q    <= 1'b1;
      rv_q        <= 1'b0;
      idx_q       <= '0;
      k_q         <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
    end else begin
      state_q <= state_d;
      rv_q    <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (op_e'(op_i))
              OP_CLEAR: begin
                cnt_q <= '0;
                ovf_q <= 1'b0;
              end
              OP_APPEND: begin
                if (we) begin
                  cnt_q <= cnt_q + CNTW'(1);
                end else begin
                  ovf_q <= 1'b1;
                end
              end
              OP_POINT: idx_q <= '0;
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          k_q <= '0;
          if (idx_q == '0 || (rd_mark && !final_v)) begin
            idx_q <= idx_q + IW'(1);
          end
        end
        ST_CALC: begin
          k_q <= k_q + STEP_W'(1);
          if (k_q == k_last && !final_v) begin
            idx_q <= idx_q + IW'(1);
          end
        end
        ST_DONE: begin
          qx_q <= px_q;
          qy_q <= py_q;
          if (last_q) begin
            rv_q        <= 1'b1;
            have_prev_q <= 1'b0;
            inside_q    <= 1'b1;
          end else begin
            have_prev_q <= 1'b1;
            inside_q    <= line_ok;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept && op_e'(op_i) == OP_POINT) begin
          px_q     <= x_i[CW-1:0];
          py_q     <= y_i[CW-1:0];
          last_q   <= last_i;
          parity_q <= 1'b0;
          onedge_q <= 1'b0;
          cross_q  <= 1'b0;
        end
      end
      ST_LOAD: begin
        ax_q <= bx_q;
        ay_q <= by_q;
        bx_q <= rd_x;
        by_q <= rd_y;
      end
      ST_CALC: begin
        if (k_q == k_last) begin
          parity_q <= parity_q ^ hit;
          onedge_q <= onedge_q | onedge;
          cross_q  <= cross_q | seg_cross;
        end
      end
      ST_DONE: begin
        within_q  <= line_ok;
        dropped_q <= ovf_q;
      end
      default: ;
    endcase
  end

  assign result_valid_o     = rv_q;
  assign within_res_o       = within_q;
  assign vertices_dropped_o = dropped_q;

endmodule

/* sv/plwp_checker.sv */
// ----------------------------------------------------------------------------
// plwp_checker
// Port-level checks for the polyline-within-polygon test core.
// ----------------------------------------------------------------------------
module plwp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] op_i,
  input logic       result_valid_o
);
  import plwp_pkg::*;

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result while busy");

  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_point_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == OP_POINT) |=> busy)
    else $error("point item did not make block busy");

  a_table_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_CLEAR || op_i == OP_APPEND))
      |=> (!busy && !result_valid_o))
    else $error("table item not single cycle");

endmodule

bind polyline_within_polygon_test_core plwp_checker u_plwp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .op_i           (op_i),
  .result_valid_o (result_valid_o)
);

/* tb/polyline_within_polygon_test_core_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_within_polygon_test_core_chk
// Watches the item and result channels of the polyline-within-polygon core.
// It keeps its own vertex table and polyline state, predicts the verdict of
// each finished polyline and compares it with what the core reports.
// ----------------------------------------------------------------------------
module polyline_within_polygon_test_core_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  input  logic        ring_start_i,
  input  logic        last_i,
  input  logic        result_valid_i,
  input  logic        within_res_i,
  input  logic        vertices_dropped_i,
  output int          errors_o,
  output int          pending_o
);
  import plwp_pkg::*;

  localparam int unsigned DEPTH = MAX_VERTICES_DEF;
  typedef logic signed [71:0] wide_t;

  typedef struct {
    logic line_ok;
    logic dropped;
  } verdict_t;

  longint   vx [DEPTH];
  longint   vy [DEPTH];
  logic     vbegin [DEPTH];
  int       nvert;
  longint   px_prev, py_prev;
  logic     has_prev, still_in, dropped_seen;
  verdict_t verdicts_q[$];

  assign pending_o = verdicts_q.size();

  function automatic int sgn(longint v);
    return (v > 0) - (v < 0);
  endfunction

  function automatic int prod_cmp(longint a, longint b, longint c, longint d);
    wide_t diff;
    diff = wide_t'(a) * wide_t'(b) - wide_t'(c) * wide_t'(d);
    return (diff > 0) - (diff < 0);
  endfunction

  function automatic bit touches(longint px, longint py, longint ax, longint ay,
                                 longint bx, longint by);
    longint x1, y1, x2, y2;
    x1 = px - ax; y1 = py - ay; x2 = px - bx; y2 = py - by;
    return prod_cmp(x1, y2, x2, y1) == 0 && sgn(x1) * sgn(x2) <= 0 &&
           sgn(y1) * sgn(y2) <= 0;
  endfunction

  function automatic bit ray_toggles(longint px, longint py, longint ax, longint ay,
                                     longint bx, longint by);
    longint nx, ny, den, dx;
    wide_t  quo, mdx;
    if ((ay > py) == (by > py)) return 0;
    nx  = bx - ax;
    ny  = py - ay;
    den = by - ay;
    quo = (wide_t'(nx < 0 ? -nx : nx) * wide_t'(ny < 0 ? -ny : ny)) /
          wide_t'(den < 0 ? -den : den);
    dx  = px - ax;
    mdx = wide_t'(dx < 0 ? -dx : dx);
    if (sgn(nx) * sgn(ny) * sgn(den) < 0) return dx < 0 && mdx > quo;
    return dx < 0 || mdx < quo;
  endfunction

  function automatic bit straddles(longint p1x, longint p1y, longint p2x, longint p2y,
                                   longint q1x, longint q1y, longint q2x, longint q2y);
    longint ex, ey;
    ex = q2x - q1x; ey = q2y - q1y;
    return prod_cmp(p1x - q1x, ey, ex, p1y - q1y) *
           prod_cmp(p2x - q1x, ey, ex, p2y - q1y) < 0;
  endfunction

  function automatic bit crosses(longint ax, longint ay, longint bx, longint by,
                                 longint cx, longint cy, longint dx, longint dy);
    if (prod_cmp(dx - cx, by - ay, dy - cy, bx - ax) == 0) return 0;
    return straddles(ax, ay, bx, by, cx, cy, dx, dy) &&
           straddles(cx, cy, dx, dy, ax, ay, bx, by);
  endfunction

  // one polyline point against the table as it stands
  function automatic bit point_ok(longint px, longint py);
    bit in_poly;
    bit ok;
    in_poly = 0;
    ok      = 1;
    for (int i = 0; i + 1 < nvert; i++) begin
      if (vbegin[i+1]) continue;
      if (touches(px, py, vx[i], vy[i], vx[i+1], vy[i+1])) ok = 0;
      if (ray_toggles(px, py, vx[i], vy[i], vx[i+1], vy[i+1])) in_poly = !in_poly;
      if (has_prev && crosses(px_prev, py_prev, px, py, vx[i], vy[i], vx[i+1], vy[i+1]))
        ok = 0;
    end
    return ok && in_poly;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    longint   px, py;
    verdict_t got;
    int       nerr;
    nerr = 0;
    if (!rst_ni) begin
      nvert = 0;
      px_prev = 0;
      py_prev = 0;
      has_prev = 0;
      still_in = 1;
      dropped_seen = 0;
      errors_o <= 0;
      verdicts_q.delete();
    end else begin
      if (result_valid_i) begin
        if (verdicts_q.size() == 0) begin
          $error("unexpected result: within_res=%0b vertices_dropped=%0b",
                 within_res_i, vertices_dropped_i);
          nerr++;
        end else begin
          got = verdicts_q.pop_front();
          if (within_res_i !== got.line_ok) begin
            $error("within_res: expected %0b, actual %0b", got.line_ok, within_res_i);
            nerr++;
          end
          if (vertices_dropped_i !== got.dropped) begin
            $error("vertices_dropped: expected %0b, actual %0b", got.dropped,
                   vertices_dropped_i);
            nerr++;
          end
        end
      end
      if (start_i && !busy_i) begin
        px = longint'($signed(x_i));
        py = longint'($signed(y_i));
        case (op_e'(op_i))
          OP_CLEAR: begin
            nvert = 0;
            dropped_seen = 0;
          end
          OP_APPEND: begin
            if (nvert < DEPTH) begin
              vx[nvert] = px;
              vy[nvert] = py;
              vbegin[nvert] = ring_start_i || nvert == 0;
              nvert = nvert + 1;
            end else begin
              dropped_seen = 1;
            end
          end
          OP_POINT: begin
            if (!point_ok(px, py)) still_in = 0;
            px_prev = px;
            py_prev = py;
            has_prev = 1;
            if (last_i) begin
              verdicts_q.push_back('{still_in, dropped_seen});
              has_prev = 0;
              still_in = 1;
            end
          end
          default: ;
        endcase
      end
      errors_o <= errors_o + nerr;
    end
  end

endmodule

/* tb/polyline_within_polygon_test_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_within_polygon_test_core_tb
// Drives polygons and polylines into the core: directed corner cases, a full
// vertex table, then random polygons with random polylines and some noise.
// A checker beside the core predicts and compares every verdict.
// ----------------------------------------------------------------------------
module polyline_within_polygon_test_core_tb;
  import plwp_pkg::*;

  localparam int LIMIT = 3000000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  op_i = OP_CLEAR;
  logic [31:0] x_i = '0;
  logic [31:0] y_i = '0;
  logic        ring_start_i = 0;
  logic        last_i = 0;
  logic        result_valid_o, within_res_o, vertices_dropped_o;
  int          errors, pending;
  int          cycles = 0;
  bit          quiet = 0;
  int          nitems = 0;

  always #1 clk_i = ~clk_i;

  polyline_within_polygon_test_core uut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .x_i, .y_i, .ring_start_i, .last_i,
    .result_valid_o, .within_res_o, .vertices_dropped_o
  );

  polyline_within_polygon_test_core_chk chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .op_i, .x_i, .y_i,
    .ring_start_i, .last_i, .result_valid_i(result_valid_o), .within_res_i(within_res_o),
    .vertices_dropped_i(vertices_dropped_o), .errors_o(errors), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("polyline_within_polygon_test_core_tb failed");
      $finish;
    end
  end

  task automatic send(op_e op, logic [31:0] x, logic [31:0] y, logic rs, logic lst);
    int gap;
    gap = (!quiet && $urandom_range(99) < 38) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1;
    op_i <= op;
    x_i <= x;
    y_i <= y;
    ring_start_i <= rs;
    last_i <= lst;
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
    nitems++;
  endtask

  function automatic logic [31:0] coord(int scale);
    case (scale)
      0: return 32'($signed($urandom_range(32)) - 16);
      1: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // one or two random rings, mostly on a cleared table, then a random polyline
  task automatic random_case();
    int          scale, nv, nr, npt;
    logic [31:0] fx, fy;
    scale = $urandom_range(9) < 7 ? 0 : ($urandom_range(2) == 0 ? 2 : 1);
    if ($urandom_range(3) != 0)
      send(OP_CLEAR, $urandom, $urandom, 1'($urandom), 1'($urandom));
    nr = $urandom_range(9) < 7 ? 1 : 2;
    for (int r = 0; r < nr; r++) begin
      nv = $urandom_range(1, 7);
      fx = coord(scale);
      fy = coord(scale);
      send(OP_APPEND, fx, fy, ($urandom_range(9) != 0), 1'($urandom));
      for (int k = 1; k < nv; k++)
        send(OP_APPEND, coord(scale), coord(scale), 0, 1'($urandom));
      if ($urandom_range(9) != 0) send(OP_APPEND, fx, fy, 0, 1'($urandom));
    end
    if ($urandom_range(9) == 0)
      send(OP_NONE, $urandom, $urandom, 1'($urandom), 1'($urandom));
    npt = $urandom_range(1, 5);
    for (int k = 0; k < npt; k++)
      send(OP_POINT, coord(scale), coord(scale), 1'($urandom), k == npt - 1);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // empty polygon, then a square at the coordinate extremes
    send(OP_POINT, 0, 0, 0, 1);
    send(OP_APPEND, 32'h8000_0000, 32'h8000_0000, 0, 1);
    send(OP_APPEND, 32'h7fff_ffff, 32'h8000_0000, 0, 0);
    send(OP_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);
    send(OP_APPEND, 32'h8000_0000, 32'h7fff_ffff, 0, 0);
    send(OP_APPEND, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send(OP_POINT, 0, 0, 1, 0);
    send(OP_POINT, 32'hffff_ffff, 32'h1234_5678, 0, 1);
    send(OP_POINT, 32'h8000_0000, 5, 0, 1);
    send(OP_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 0, 1);
    // hole ring: segment through it crosses, point inside it is outside
    send(OP_APPEND, -10, -10, 1, 0);
    send(OP_APPEND, 10, -10, 0, 0);
    send(OP_APPEND, 10, 10, 0, 0);
    send(OP_APPEND, -10, 10, 0, 0);
    send(OP_APPEND, -10, -10, 0, 0);
    send(OP_NONE, 100, 100, 1, 1);
    send(OP_POINT, -20, 0, 0, 0);
    send(OP_POINT, 20, 0, 0, 1);
    send(OP_POINT, 0, 0, 0, 1);
    send(OP_POINT, 50, 50, 0, 0);
    send(OP_CLEAR, 0, 0, 1, 1);
    send(OP_POINT, 60, 60, 0, 1);

    // full table and a dropped append
    for (int k = 0; k <= MAX_VERTICES_DEF; k++)
      send(OP_APPEND, 32'(k % 7), 32'(k % 5), 0, 0);
    send(OP_POINT, 1, 1, 0, 1);
    send(OP_CLEAR, 0, 0, 0, 0);
    send(OP_POINT, 1, 1, 0, 1);

    start <= 0;
    wait (pending == 0);
    @(posedge clk_i);

    nitems = 0;
    while (nitems < 580) begin
      quiet = nitems > 200 && nitems < 300;
      random_case();
      if ($urandom_range(15) == 0) begin
        start <= 0;
        wait (pending == 0);
        @(posedge clk_i);
      end
    end

    start <= 0;
    wait (pending == 0);
    do @(negedge clk_i); while (busy);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("polyline_within_polygon_test_core_tb passed");
    end else begin
      $display("polyline_within_polygon_test_core_tb failed");
    end
    $finish;
  end

endmodule
